/* hw/rtl/scp_pkg.sv */
`default_nettype none
package scp_pkg;
    parameter int COORD_WIDTH_DEF = 32;
    parameter int FRAC_BITS       = 16;
    parameter int FRAC_ONE        = 1 << FRAC_BITS;
    parameter int LIMIT_WIDTH     = 16;
    parameter logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd1;
endpackage
`default_nettype wire

/* hw/rtl/scp_if.sv */
`default_nettype none
interface scp_seg_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] from_a_x, from_a_y, from_a_z;
    logic signed [COORD_WIDTH-1:0] to_a_x, to_a_y, to_a_z;
    logic signed [COORD_WIDTH-1:0] from_b_x, from_b_y, from_b_z;
    logic signed [COORD_WIDTH-1:0] to_b_x, to_b_y, to_b_z;
    modport source (output valid, from_a_x, from_a_y, from_a_z, to_a_x, to_a_y, to_a_z,
                    from_b_x, from_b_y, from_b_z, to_b_x, to_b_y, to_b_z, input ready);
    modport sink (input valid, from_a_x, from_a_y, from_a_z, to_a_x, to_a_y, to_a_z,
                  from_b_x, from_b_y, from_b_z, to_b_x, to_b_y, to_b_z, output ready);
endinterface

interface scp_pts_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] near_a_x, near_a_y, near_a_z;
    logic signed [COORD_WIDTH-1:0] near_b_x, near_b_y, near_b_z;
    logic        [COORD_WIDTH-2:0] separation;
    modport source (output valid, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y,
                    near_b_z, separation, input ready);
    modport sink (input valid, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y,
                  near_b_z, separation, output ready);
endinterface
`default_nettype wire

/* hw/rtl/scp_quot.sv */
`default_nettype none
module scp_quot #(
    parameter int NW = 64,
    parameter int TW = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [NW-1:0] den,
    input  wire logic        [TW-1:0] tag_in,
    output      logic                 out_valid,
    output      logic [scp_pkg::FRAC_BITS:0] quo,
    output      logic        [TW-1:0] tag_out
);
    import scp_pkg::*;
    localparam int QW = FRAC_BITS + 1;

    logic [NW-1:0] n_reg   [0:FRAC_BITS];
    logic [NW-1:0] d_reg   [0:FRAC_BITS];
    logic [QW-1:0] q_reg   [0:FRAC_BITS];
    logic [TW-1:0] tag_reg [0:FRAC_BITS];
    logic          act_reg [0:FRAC_BITS];
    logic          v_reg   [0:FRAC_BITS];

    logic [NW-1:0] n0_next;
    logic [QW-1:0] q0_next;
    logic          act0_next;

    // clamp cases first, then one quotient bit per stage
    always_comb
    begin
        n0_next   = num;
        q0_next   = '0;
        act0_next = 1'b0;
        if (num <= 0)
        begin
            q0_next = '0;
        end
        else if (num >= den)
        begin
            q0_next = QW'(FRAC_ONE);
        end
        else
        begin
            act0_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= n0_next;
            d_reg[0]   <= den;
            q_reg[0]   <= q0_next;
            act_reg[0] <= act0_next;
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar i = 1; i <= FRAC_BITS; i++)
    begin : g_step
        logic [NW:0]   nsh;
        logic          dge;
        logic [NW-1:0] n_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            nsh    = {n_reg[i-1], 1'b0};
            dge    = nsh >= {1'b0, d_reg[i-1]};
            n_next = n_reg[i-1];
            q_next = q_reg[i-1];
            if (act_reg[i-1])
            begin
                n_next = dge ? NW'(nsh - {1'b0, d_reg[i-1]}) : nsh[NW-1:0];
                q_next = {q_reg[i-1][QW-2:0], dge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]   <= n_next;
                d_reg[i]   <= d_reg[i-1];
                q_reg[i]   <= q_next;
                act_reg[i] <= act_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[FRAC_BITS];
    assign quo       = q_reg[FRAC_BITS];
    assign tag_out   = tag_reg[FRAC_BITS];
endmodule
`default_nettype wire

/* hw/rtl/scp_sqrt.sv */
`default_nettype none
module scp_sqrt #(
    parameter int RW = 31,
    parameter int VW = 68,
    parameter int TW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [VW-1:0] val,
    input  wire logic [TW-1:0] tag_in,
    output      logic          out_valid,
    output      logic [RW-1:0] root,
    output      logic [TW-1:0] tag_out
);
    logic [VW-1:0] rem_reg  [0:RW];
    logic [RW-1:0] root_reg [0:RW];
    logic [TW-1:0] tag_reg  [0:RW];
    logic          v_reg    [0:RW];
    logic [RW-1:0] fin_reg;
    logic [TW-1:0] fin_tag_reg;
    logic          fin_v_reg;
    logic [RW-1:0] fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= val;
            root_reg[0] <= '0;
            tag_reg[0]  <= tag_in;
        end
    end

    // one root bit per stage, most significant first
    for (genvar i = 1; i <= RW; i++)
    begin : g_bit
        localparam int K = RW - i;
        logic [VW-1:0] trial;
        logic          take;

        always_comb
        begin
            trial = (VW'(root_reg[i-1]) << (K + 1)) | (VW'(1) << (2 * K));
            take  = rem_reg[i-1] >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? rem_reg[i-1] - trial : rem_reg[i-1];
                root_reg[i] <= take ? (root_reg[i-1] | (RW'(1) << K)) : root_reg[i-1];
                tag_reg[i]  <= tag_reg[i-1];
            end
        end
    end

    // round to nearest unless already saturated
    always_comb
    begin
        fin_next = root_reg[RW];
        if ((root_reg[RW] != {RW{1'b1}}) && (rem_reg[RW] > VW'(root_reg[RW])))
        begin
            fin_next = root_reg[RW] + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_v_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_v_reg <= v_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg     <= fin_next;
            fin_tag_reg <= tag_reg[RW];
        end
    end

    assign out_valid = fin_v_reg;
    assign root      = fin_reg;
    assign tag_out   = fin_tag_reg;
endmodule
`default_nettype wire

/* hw/rtl/segment_closest_points_top.sv */
`default_nettype none
// closest points between two 3d segments, one segment pair per beat. coordinates are
// signed q24.8 (COORD_WIDTH bits); the block returns the nearest point on each segment
// and their distance, rounded to nearest and saturating. it is one pipeline that takes
// a beat every cycle unless held; most of its depth lies in the two bit-per-stage
// quotient units and the bit-per-stage square root. the whole pipeline holds while
// the output beat waits, so nothing is lost or repeated. cfg_we/cfg_data write
// degenerate_limit (reset 1), the limit on squared lengths in q.16; the denominator
// is tested against it shifted up 16 bits.
// write it only while the pipeline is empty.
module segment_closest_points_top #(
    parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [scp_pkg::LIMIT_WIDTH-1:0]    cfg_data,
    scp_seg_if.sink                                 segs,
    scp_pts_if.source                               points
);
    import scp_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int D   = W + 1;          // differences
    localparam int DW  = 2 * D + 2;      // dot products
    localparam int HW  = DW / 2;         // halves of a dot product for split multiplies
    localparam int PW  = 2 * DW;         // products of dot products
    localparam int NW1 = PW + 2;         // first quotient operands
    localparam int NW2 = DW + 20;        // second quotient operands
    localparam int QW  = FRAC_BITS + 1;
    localparam int SW  = D + QW + 1;     // difference times fraction
    localparam int RW  = W - 1;

    typedef struct packed {
        logic [2:0][W-1:0] fa;
        logic [2:0][W-1:0] fb;
        logic [2:0][D-1:0] d1;
        logic [2:0][D-1:0] d2;
    } geo_t;

    typedef struct packed {
        logic [DW-1:0] len1;
        logic [DW-1:0] len2;
        logic [DW-1:0] f;
        logic [DW-1:0] c;
        logic [DW-1:0] b;
        logic          deg1;
        logic          deg2;
    } dots_t;

    typedef struct packed {
        geo_t  geo;
        dots_t dots;
    } tag1_t;

    typedef struct packed {
        geo_t          geo;
        logic          q_to_s;   // second quotient is s, else t
        logic [QW-1:0] other;    // the parameter that is already known
    } tag2_t;

    typedef struct packed {
        logic [2:0][W-1:0] pa;
        logic [2:0][W-1:0] pb;
    } pts_t;

    // partial products of one dot product by another, high and low halves
    typedef struct packed {
        logic [2*HW-1:0] hh;     // signed high times high
        logic [2*HW:0]   hl;     // signed high times low
        logic [2*HW:0]   lh;     // signed low times high
        logic [2*HW-1:0] ll;     // unsigned low times low
    } pp_t;

    // configuration
    logic [LIMIT_WIDTH-1:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            lim_reg <= cfg_data;
        end
    end

    // whole pipeline advances together, held only by a waiting output beat
    logic en;
    logic out_v;
    assign en         = !out_v || points.ready;
    assign segs.ready = en;

    // stage 1: differences
    logic [2:0][W-1:0] in_fa, in_ta, in_fb, in_tb;
    assign in_fa = {segs.from_a_z, segs.from_a_y, segs.from_a_x};
    assign in_ta = {segs.to_a_z, segs.to_a_y, segs.to_a_x};
    assign in_fb = {segs.from_b_z, segs.from_b_y, segs.from_b_x};
    assign in_tb = {segs.to_b_z, segs.to_b_y, segs.to_b_x};

    logic              v1_reg;
    geo_t              geo1_reg;
    logic [2:0][D-1:0] r1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                geo1_reg.fa[i] <= in_fa[i];
                geo1_reg.fb[i] <= in_fb[i];
                geo1_reg.d1[i] <= D'($signed(in_ta[i])) - D'($signed(in_fa[i]));
                geo1_reg.d2[i] <= D'($signed(in_tb[i])) - D'($signed(in_fb[i]));
                r1_reg[i]      <= D'($signed(in_fa[i])) - D'($signed(in_fb[i]));
            end
        end
    end

    // stage 2: the fifteen coordinate products
    logic                  v2_reg;
    geo_t                  geo2_reg;
    logic [2:0][2*D-1:0]   p11_reg, p22_reg, pf_reg, pc_reg, pb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo2_reg <= geo1_reg;
            for (int i = 0; i < 3; i++)
            begin
                p11_reg[i] <= $signed(geo1_reg.d1[i]) * $signed(geo1_reg.d1[i]);
                p22_reg[i] <= $signed(geo1_reg.d2[i]) * $signed(geo1_reg.d2[i]);
                pf_reg[i]  <= $signed(geo1_reg.d2[i]) * $signed(r1_reg[i]);
                pc_reg[i]  <= $signed(geo1_reg.d1[i]) * $signed(r1_reg[i]);
                pb_reg[i]  <= $signed(geo1_reg.d1[i]) * $signed(geo1_reg.d2[i]);
            end
        end
    end

    // stage 3: dot products and degenerate tests
    function automatic logic [DW-1:0] sum3(input logic [2:0][2*D-1:0] p);
        return DW'($signed(p[0])) + DW'($signed(p[1])) + DW'($signed(p[2]));
    endfunction

    logic          v3_reg;
    geo_t          geo3_reg;
    dots_t         dots3_next;
    dots_t         dots3_reg;

    always_comb
    begin
        dots3_next.len1 = sum3(p11_reg);
        dots3_next.len2 = sum3(p22_reg);
        dots3_next.f    = sum3(pf_reg);
        dots3_next.c    = sum3(pc_reg);
        dots3_next.b    = sum3(pb_reg);
        dots3_next.deg1 = $signed(dots3_next.len1) <= $signed(DW'(lim_reg));
        dots3_next.deg2 = $signed(dots3_next.len2) <= $signed(DW'(lim_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo3_reg  <= geo2_reg;
            dots3_reg <= dots3_next;
        end
    end

    // wide signed multiply cut into four half-width products
    function automatic pp_t split_mul(input logic [DW-1:0] a, input logic [DW-1:0] b);
        pp_t r;
        r.hh = $signed(a[DW-1:HW]) * $signed(b[DW-1:HW]);
        r.hl = $signed(a[DW-1:HW]) * $signed({1'b0, b[HW-1:0]});
        r.lh = $signed({1'b0, a[HW-1:0]}) * $signed(b[DW-1:HW]);
        r.ll = a[HW-1:0] * b[HW-1:0];
        return r;
    endfunction

    function automatic logic [PW-1:0] join_mul(input pp_t p);
        return (PW'($signed(p.hh)) << (2 * HW)) + (PW'($signed(p.hl)) << HW)
             + (PW'($signed(p.lh)) << HW) + PW'(p.ll);
    endfunction

    // stage 4, first half: partial products for the unclamped s
    logic          v4p_reg;
    tag1_t         tag4p_reg;
    pp_t           bf4p_reg, cl4p_reg, ll4p_reg, bb4p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag4p_reg.geo  <= geo3_reg;
            tag4p_reg.dots <= dots3_reg;
            bf4p_reg <= split_mul(dots3_reg.b, dots3_reg.f);
            cl4p_reg <= split_mul(dots3_reg.c, dots3_reg.len2);
            ll4p_reg <= split_mul(dots3_reg.len1, dots3_reg.len2);
            bb4p_reg <= split_mul(dots3_reg.b, dots3_reg.b);
        end
    end

    // stage 4, second half: full products
    logic          v4_reg;
    tag1_t         tag4_reg;
    logic [PW-1:0] bf4_reg, cl4_reg, ll4_reg, bb4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag4_reg <= tag4p_reg;
            bf4_reg  <= join_mul(bf4p_reg);
            cl4_reg  <= join_mul(cl4p_reg);
            ll4_reg  <= join_mul(ll4p_reg);
            bb4_reg  <= join_mul(bb4p_reg);
        end
    end

    // stage 5: numerator and denominator; parallel or degenerate pairs start at s = 0
    logic           v5_reg;
    tag1_t          tag5_reg;
    logic [NW1-1:0] num5_next, den5_next, num5_reg, den5_reg;
    logic           solve5;

    always_comb
    begin
        num5_next = NW1'($signed(bf4_reg)) - NW1'($signed(cl4_reg));
        den5_next = NW1'($signed(ll4_reg)) - NW1'($signed(bb4_reg));
        solve5    = !tag4_reg.dots.deg1 && !tag4_reg.dots.deg2 &&
                    ($signed(den5_next) > $signed(NW1'(lim_reg) << FRAC_BITS));
        if (!solve5)
        begin
            num5_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag5_reg <= tag4_reg;
            num5_reg <= num5_next;
            den5_reg <= den5_next;
        end
    end

    // first quotient: s before clamping t
    logic          vq1;
    logic [QW-1:0] s0q1;
    tag1_t         tagq1;

    scp_quot #(.NW(NW1), .TW($bits(tag1_t))) u_quot_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v5_reg),
        .num      (num5_reg),
        .den      (den5_reg),
        .tag_in   (tag5_reg),
        .out_valid(vq1),
        .quo      (s0q1),
        .tag_out  (tagq1)
    );

    // stage 6: b * s, as high and low halves of b
    logic                v6_reg;
    tag1_t               tag6_reg;
    logic [QW-1:0]       s06_reg;
    logic [HW+QW-1:0]    bsl6_reg;
    logic [HW+QW:0]      bsh6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag6_reg <= tagq1;
            s06_reg  <= s0q1;
            bsl6_reg <= tagq1.dots.b[HW-1:0] * s0q1;
            bsh6_reg <= $signed(tagq1.dots.b[DW-1:HW]) * $signed({1'b0, s0q1});
        end
    end

    // stage 7: t numerator, clamping, choice of the second quotient
    logic           v7_reg;
    tag2_t          tag7_next, tag7_reg;
    logic [NW2-1:0] tn7, l2s7, num7_next, den7_next, num7_reg, den7_reg;

    always_comb
    begin
        tn7  = (NW2'($signed(bsh6_reg)) << HW) + NW2'(bsl6_reg)
             + (NW2'($signed(tag6_reg.dots.f)) << FRAC_BITS);
        l2s7 = NW2'($signed(tag6_reg.dots.len2)) << FRAC_BITS;
        tag7_next.geo    = tag6_reg.geo;
        tag7_next.q_to_s = 1'b1;
        tag7_next.other  = '0;
        num7_next = '0;
        den7_next = NW2'($signed(tag6_reg.dots.len1));
        if (tag6_reg.dots.deg1 && tag6_reg.dots.deg2)
        begin
            num7_next = '0;              // both points are the start points
        end
        else if (tag6_reg.dots.deg1)
        begin
            tag7_next.q_to_s = 1'b0;
            num7_next = NW2'($signed(tag6_reg.dots.f));
            den7_next = NW2'($signed(tag6_reg.dots.len2));
        end
        else if (tag6_reg.dots.deg2 || tn7[NW2-1])
        begin
            num7_next = -NW2'($signed(tag6_reg.dots.c));
        end
        else if ($signed(tn7) > $signed(l2s7))
        begin
            tag7_next.other = QW'(FRAC_ONE);
            num7_next = NW2'($signed(tag6_reg.dots.b)) - NW2'($signed(tag6_reg.dots.c));
        end
        else
        begin
            tag7_next.q_to_s = 1'b0;
            tag7_next.other  = s06_reg;
            num7_next = tn7;
            den7_next = l2s7;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag7_reg <= tag7_next;
            num7_reg <= num7_next;
            den7_reg <= den7_next;
        end
    end

    // second quotient: the clamped s, or t
    logic          vq2;
    logic [QW-1:0] q2;
    tag2_t         tagq2;

    scp_quot #(.NW(NW2), .TW($bits(tag2_t))) u_quot_st (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v7_reg),
        .num      (num7_reg),
        .den      (den7_reg),
        .tag_in   (tag7_reg),
        .out_valid(vq2),
        .quo      (q2),
        .tag_out  (tagq2)
    );

    // stage 8: direction times parameter
    logic              v8_reg;
    logic [2:0][W-1:0] fa8_reg, fb8_reg;
    logic [2:0][SW-1:0] ps8_reg, pt8_reg;
    logic [QW-1:0]     s8, t8;

    assign s8 = tagq2.q_to_s ? q2 : tagq2.other;
    assign t8 = tagq2.q_to_s ? tagq2.other : q2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa8_reg <= tagq2.geo.fa;
            fb8_reg <= tagq2.geo.fb;
            for (int i = 0; i < 3; i++)
            begin
                ps8_reg[i] <= $signed(tagq2.geo.d1[i]) * $signed({1'b0, s8});
                pt8_reg[i] <= $signed(tagq2.geo.d2[i]) * $signed({1'b0, t8});
            end
        end
    end

    // stage 9: rounded points and their difference
    function automatic logic [W-1:0] along(input logic [W-1:0] from, input logic [SW-1:0] p);
        logic [SW:0] rnd;
        rnd = (SW+1)'($signed(p)) + (SW+1)'(FRAC_ONE / 2);
        return from + W'($signed(rnd) >>> FRAC_BITS);
    endfunction

    logic              v9_reg;
    pts_t              pts9_next, pts9_reg;
    logic [2:0][D-1:0] e9_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pts9_next.pa[i] = along(fa8_reg[i], ps8_reg[i]);
            pts9_next.pb[i] = along(fb8_reg[i], pt8_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pts9_reg <= pts9_next;
            for (int i = 0; i < 3; i++)
            begin
                e9_reg[i] <= D'($signed(pts9_next.pa[i])) - D'($signed(pts9_next.pb[i]));
            end
        end
    end

    // stage 10: squares, stage 11: squared distance
    logic                v10_reg, v11_reg;
    pts_t                pts10_reg, pts11_reg;
    logic [2:0][2*D-1:0] ee10_reg;
    logic [DW-1:0]       dd11_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pts10_reg <= pts9_reg;
            for (int i = 0; i < 3; i++)
            begin
                ee10_reg[i] <= $signed(e9_reg[i]) * $signed(e9_reg[i]);
            end
            pts11_reg <= pts10_reg;
            dd11_reg  <= sum3(ee10_reg);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4p_reg <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= segs.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4p_reg <= v3_reg;
            v4_reg  <= v4p_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= vq1;
            v7_reg  <= v6_reg;
            v8_reg  <= vq2;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    // distance; its last stage is the output register
    pts_t          pts_out;
    logic [RW-1:0] sep_out;

    scp_sqrt #(.RW(RW), .VW(DW), .TW($bits(pts_t))) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v11_reg),
        .val      (dd11_reg),
        .tag_in   (pts11_reg),
        .out_valid(out_v),
        .root     (sep_out),
        .tag_out  (pts_out)
    );

    assign points.valid      = out_v;
    assign points.near_a_x   = pts_out.pa[0];
    assign points.near_a_y   = pts_out.pa[1];
    assign points.near_a_z   = pts_out.pa[2];
    assign points.near_b_x   = pts_out.pb[0];
    assign points.near_b_y   = pts_out.pb[1];
    assign points.near_b_z   = pts_out.pb[2];
    assign points.separation = sep_out;
endmodule
`default_nettype wire
